// File: rtl/core/range_bearing_pair_midpoint_unit_assert.svh
// ----------------------------------------------------------------------------
// Range/bearing midpoint assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RANGE_BEARING_PAIR_MIDPOINT_UNIT_ASSERT_SVH
`define RANGE_BEARING_PAIR_MIDPOINT_UNIT_ASSERT_SVH

// same-cycle implication, reset masked
`define RBPM_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbpm assertion failed");

// next-cycle implication, reset masked
`define RBPM_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbpm assertion failed");

`endif

// File: rtl/core/rbpm_pkg.sv
// ----------------------------------------------------------------------------
// rbpm_pkg
// Widths, CORDIC constants and the arctangent table for the midpoint unit.
// ----------------------------------------------------------------------------
package rbpm_pkg;

	localparam int CORDIC_STAGES_DEF = 18;
	localparam int ZW  = 34;   // angle accumulator, Q30
	localparam int XW  = 34;   // CORDIC x/y, Q30
	localparam int CW  = 32;   // sin/cos result, Q30
	localparam int RW  = 24;   // range, Q8.16
	localparam int AW  = 19;   // angle, Q2.16
	localparam int MW  = 24;   // mount offset, Q8.16
	localparam int OW  = 27;   // coordinates, Q10.16
	localparam int PW  = RW + 1 + CW;   // range * cos
	localparam int SW  = 33;   // Q22 point sum
	localparam int QW  = CW + SW;       // rotation products
	localparam int IDXW = 2;

	localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [XW-1:0] Q30_GAIN    = 34'sd652032874;

	typedef enum logic [IDXW-1:0] {
		REG_MOUNT_YAW = 2'd0,
		REG_MOUNT_X   = 2'd1,
		REG_MOUNT_Y   = 2'd2
	} reg_idx_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = 34'sd843314856;
			1: a = 34'sd497837829;
			2: a = 34'sd263043836;
			3: a = 34'sd133525158;
			4: a = 34'sd67021686;
			5: a = 34'sd33543515;
			6: a = 34'sd16775850;
			7: a = 34'sd8388437;
			8: a = 34'sd4194282;
			9: a = 34'sd2097149;
			10: a = 34'sd1048575;
			11: a = 34'sd524287;
			12: a = 34'sd262143;
			13: a = 34'sd131071;
			14: a = 34'sd65535;
			15: a = 34'sd32767;
			16: a = 34'sd16383;
			17: a = 34'sd8191;
			18: a = 34'sd4095;
			19: a = 34'sd2047;
			20: a = 34'sd1023;
			21: a = 34'sd511;
			22: a = 34'sd255;
			23: a = 34'sd127;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/core/range_bearing_pair_midpoint_unit.sv
// ----------------------------------------------------------------------------
// range_bearing_pair_midpoint_unit
// Two range/bearing returns in, scanner-frame and world-frame midpoints out.
// ----------------------------------------------------------------------------
// One pair enters per cycle while in_stall is low. An accepted request
// passes through the fold, one stage per CORDIC iteration, sign restore,
// range multiply, sum, rotation multiply and output stages. Three CORDIC
// lanes run side by side: both bearings and the mounting yaw. Each stage
// holds only when it is full and the stage after it holds, so empty slots
// close up under out_stall; while a result waits, input is taken if a
// slot is empty. Configuration writes are always ready; write them only while idle.
module range_bearing_pair_midpoint_unit #(
	parameter int CORDIC_STAGES = rbpm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rbpm_pkg::IDXW-1:0]          cfg_index,
	input  logic [rbpm_pkg::MW-1:0]            cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rbpm_pkg::RW-1:0]            range_first,
	input  logic signed [rbpm_pkg::AW-1:0]     bearing_first,
	input  logic [rbpm_pkg::RW-1:0]            range_second,
	input  logic signed [rbpm_pkg::AW-1:0]     bearing_second,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [rbpm_pkg::OW-1:0]     mid_scan_x,
	output logic signed [rbpm_pkg::OW-1:0]     mid_scan_y,
	output logic signed [rbpm_pkg::OW-1:0]     mid_world_x,
	output logic signed [rbpm_pkg::OW-1:0]     mid_world_y
);

	localparam int N  = CORDIC_STAGES;
	localparam int L  = N + 6;
	localparam int SP = N + 2;   // range products
	localparam int SS = N + 3;   // point sums
	localparam int SR = N + 4;   // rotation products
	localparam int SO = N + 5;   // output

	logic signed [rbpm_pkg::AW-1:0] yaw_q;
	logic signed [rbpm_pkg::MW-1:0] mx_q, my_q;
	logic [L-1:0] en, v;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q <= '0;
			mx_q  <= '0;
			my_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rbpm_pkg::REG_MOUNT_YAW: yaw_q <= cfg_data[rbpm_pkg::AW-1:0];
				rbpm_pkg::REG_MOUNT_X:   mx_q  <= cfg_data;
				rbpm_pkg::REG_MOUNT_Y:   my_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid chain with bubble collapse
	assign en[L-1] = ~v[L-1] | ~out_stall;
	for (genvar i = 0; i < L - 1; i++) begin : g_en
		assign en[i] = ~v[i] | en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[0])
				v[0] <= in_valid;
			for (int i = 1; i < L; i++) begin
				if (en[i])
					v[i] <= v[i-1];
			end
		end
	end

	assign in_stall  = ~en[0];
	assign out_valid = v[L-1];

	// CORDIC lanes
	logic signed [rbpm_pkg::CW-1:0] c1, s1, c2, s2, cy, sy;

	rbpm_cordic #(.CORDIC_STAGES(N)) u_cordic_first (
		.clk(clk), .en(en[N+1:0]), .angle(bearing_first), .cos_o(c1), .sin_o(s1)
	);
	rbpm_cordic #(.CORDIC_STAGES(N)) u_cordic_second (
		.clk(clk), .en(en[N+1:0]), .angle(bearing_second), .cos_o(c2), .sin_o(s2)
	);
	rbpm_cordic #(.CORDIC_STAGES(N)) u_cordic_yaw (
		.clk(clk), .en(en[N+1:0]), .angle(yaw_q), .cos_o(cy), .sin_o(sy)
	);

	// ranges ride alongside the CORDIC stages
	logic [rbpm_pkg::RW-1:0] r1_s [0:N+1];
	logic [rbpm_pkg::RW-1:0] r2_s [0:N+1];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			r1_s[0] <= range_first;
			r2_s[0] <= range_second;
		end
		for (int i = 1; i <= N + 1; i++) begin
			if (en[i]) begin
				r1_s[i] <= r1_s[i-1];
				r2_s[i] <= r2_s[i-1];
			end
		end
	end

	// range * cos/sin, Q46
	logic signed [rbpm_pkg::PW-1:0] px1_sp, py1_sp, px2_sp, py2_sp;
	logic signed [rbpm_pkg::CW-1:0] cy_sp, sy_sp, cy_ss, sy_ss;

	always_ff @(posedge clk) begin
		if (en[SP]) begin
			px1_sp <= $signed({1'b0, r1_s[N+1]}) * c1;
			py1_sp <= $signed({1'b0, r1_s[N+1]}) * s1;
			px2_sp <= $signed({1'b0, r2_s[N+1]}) * c2;
			py2_sp <= $signed({1'b0, r2_s[N+1]}) * s2;
			cy_sp  <= cy;
			sy_sp  <= sy;
		end
	end

	// round to Q22 and sum the pair
	localparam logic signed [rbpm_pkg::PW-1:0] HALF24 = rbpm_pkg::PW'(1) <<< 23;
	logic signed [rbpm_pkg::PW-1:0] rx1, ry1, rx2, ry2;
	logic signed [rbpm_pkg::SW-1:0] sum_x_ss, sum_y_ss;

	assign rx1 = (px1_sp + HALF24) >>> 24;
	assign ry1 = (py1_sp + HALF24) >>> 24;
	assign rx2 = (px2_sp + HALF24) >>> 24;
	assign ry2 = (py2_sp + HALF24) >>> 24;

	always_ff @(posedge clk) begin
		if (en[SS]) begin
			sum_x_ss <= $signed(rx1[rbpm_pkg::SW-1:0]) + $signed(rx2[rbpm_pkg::SW-1:0]);
			sum_y_ss <= $signed(ry1[rbpm_pkg::SW-1:0]) + $signed(ry2[rbpm_pkg::SW-1:0]);
			cy_ss    <= cy_sp;
			sy_ss    <= sy_sp;
		end
	end

	// rotate by mounting yaw, Q52
	logic signed [rbpm_pkg::QW-1:0] cx_sr, sy_x_sr, sx_sr, cy_y_sr;
	logic signed [rbpm_pkg::SW-1:0] sum_x_sr, sum_y_sr;

	always_ff @(posedge clk) begin
		if (en[SR]) begin
			cx_sr    <= cy_ss * sum_x_ss;
			sy_x_sr  <= sy_ss * sum_y_ss;
			sx_sr    <= sy_ss * sum_x_ss;
			cy_y_sr  <= cy_ss * sum_y_ss;
			sum_x_sr <= sum_x_ss;
			sum_y_sr <= sum_y_ss;
		end
	end

	// halve with rounding, add mount offset
	localparam int WW = rbpm_pkg::QW + 1;
	localparam logic signed [WW-1:0] HALF37 = WW'(1) <<< 36;
	localparam logic signed [rbpm_pkg::SW-1:0] HALF7 = rbpm_pkg::SW'(64);
	logic signed [WW-1:0] wx, wy, wxr, wyr;
	logic signed [rbpm_pkg::SW-1:0] msx, msy;

	assign wx  = WW'(cx_sr) - WW'(sy_x_sr);
	assign wy  = WW'(sx_sr) + WW'(cy_y_sr);
	assign wxr = (wx + HALF37) >>> 37;
	assign wyr = (wy + HALF37) >>> 37;
	assign msx = (sum_x_sr + HALF7) >>> 7;
	assign msy = (sum_y_sr + HALF7) >>> 7;

	always_ff @(posedge clk) begin
		if (en[SO]) begin
			mid_scan_x  <= msx[rbpm_pkg::OW-1:0];
			mid_scan_y  <= msy[rbpm_pkg::OW-1:0];
			mid_world_x <= wxr[rbpm_pkg::OW-1:0] + rbpm_pkg::OW'(mx_q);
			mid_world_y <= wyr[rbpm_pkg::OW-1:0] + rbpm_pkg::OW'(my_q);
		end
	end

endmodule

// File: rtl/core/rbpm_cordic.sv
// ----------------------------------------------------------------------------
// rbpm_cordic
// Pipelined rotation-mode CORDIC lane: quadrant fold, one register per
// iteration, sign restore. Stage i loads when en[i] is high.
// ----------------------------------------------------------------------------
module rbpm_cordic #(
	parameter int CORDIC_STAGES = rbpm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic [CORDIC_STAGES+1:0]           en,
	input  logic signed [rbpm_pkg::AW-1:0]     angle,
	output logic signed [rbpm_pkg::CW-1:0]     cos_o,
	output logic signed [rbpm_pkg::CW-1:0]     sin_o
);

	localparam int N = CORDIC_STAGES;

	logic signed [rbpm_pkg::ZW-1:0] z_s [0:N];
	logic signed [rbpm_pkg::XW-1:0] x_s [0:N];
	logic signed [rbpm_pkg::XW-1:0] y_s [0:N];
	logic                           neg_s [0:N];
	logic signed [rbpm_pkg::ZW-1:0] z_in;

	assign z_in = rbpm_pkg::ZW'($signed({angle, 14'b0}));

	// fold beyond +-pi/2, negate at the end
	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s[0] <= rbpm_pkg::Q30_GAIN;
			y_s[0] <= '0;
			if (z_in > rbpm_pkg::Q30_HALF_PI) begin
				z_s[0]   <= z_in - rbpm_pkg::Q30_PI;
				neg_s[0] <= 1'b1;
			end else if (z_in < -rbpm_pkg::Q30_HALF_PI) begin
				z_s[0]   <= z_in + rbpm_pkg::Q30_PI;
				neg_s[0] <= 1'b1;
			end else begin
				z_s[0]   <= z_in;
				neg_s[0] <= 1'b0;
			end
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_iter
		localparam logic signed [rbpm_pkg::ZW-1:0] ATAN = rbpm_pkg::atan_q30(k - 1);
		always_ff @(posedge clk) begin
			if (en[k]) begin
				neg_s[k] <= neg_s[k-1];
				if (!z_s[k-1][rbpm_pkg::ZW-1]) begin
					x_s[k] <= x_s[k-1] - (y_s[k-1] >>> (k - 1));
					y_s[k] <= y_s[k-1] + (x_s[k-1] >>> (k - 1));
					z_s[k] <= z_s[k-1] - ATAN;
				end else begin
					x_s[k] <= x_s[k-1] + (y_s[k-1] >>> (k - 1));
					y_s[k] <= y_s[k-1] - (x_s[k-1] >>> (k - 1));
					z_s[k] <= z_s[k-1] + ATAN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[N+1]) begin
			cos_o <= neg_s[N] ? rbpm_pkg::CW'(-x_s[N]) : rbpm_pkg::CW'(x_s[N]);
			sin_o <= neg_s[N] ? rbpm_pkg::CW'(-y_s[N]) : rbpm_pkg::CW'(y_s[N]);
		end
	end

endmodule

// File: rtl/core/rbpm_checker.sv
// ----------------------------------------------------------------------------
// rbpm_checker
// Port-level checks for the midpoint unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "range_bearing_pair_midpoint_unit_assert.svh"

module rbpm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [rbpm_pkg::OW-1:0]        mid_scan_x,
	input logic [rbpm_pkg::OW-1:0]        mid_scan_y,
	input logic [rbpm_pkg::OW-1:0]        mid_world_x,
	input logic [rbpm_pkg::OW-1:0]        mid_world_y
);

	// an empty or draining output means the pipe can always take a request
	`RBPM_AST_NOW(a_empty_takes, !out_valid, !in_stall)
	`RBPM_AST_NOW(a_drain_takes, !out_stall, !in_stall)
	`RBPM_AST_NEXT(a_valid_holds, out_valid && out_stall, out_valid)
	`RBPM_AST_NEXT(a_data_holds, out_valid && out_stall, $stable(mid_scan_x) && $stable(mid_scan_y) && $stable(mid_world_x) && $stable(mid_world_y))

endmodule

bind range_bearing_pair_midpoint_unit rbpm_checker u_rbpm_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .mid_scan_x(mid_scan_x), .mid_scan_y(mid_scan_y),
	.mid_world_x(mid_world_x), .mid_world_y(mid_world_y)
);
